// ----- hdl/bbd_pkg.sv -----
// Shared constants and types for the Bayer bilinear demosaic block.
package bbd_pkg;

    // Longest row held in the line stores.
    localparam int MAX_WIDTH = 2048;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    // Drain counter, next-column count and clamped width reach MAX_WIDTH itself.
    localparam int CNT_W     = $clog2(MAX_WIDTH) + 1;
    localparam int PIX_W     = 8;
    localparam int CFG_W     = 12;
    localparam int ROWS_W    = 2;

    localparam logic [CFG_W-1:0] WIDTH_RESET = CFG_W'(390);

    // Line store word: {row two back, previous row}.
    localparam int LS_W = 2 * PIX_W;

    // Control carried from the address stage to the window stage.
    typedef struct packed {
        logic              emit;
        logic              drain;
        logic              zero_read;
        logic              top_inv;
        logic              bot_inv;
        logic              left;
        logic              right;
        logic              rpar;
        logic              cpar;
        logic              frame_end;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pix;
    } s1_ctrl_t;

endpackage

// ----- hdl/bbd_ram.sv -----
// Generic simple dual-port RAM with registered read data.
module bbd_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [DATA_W-1:0]        wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [DATA_W-1:0]        rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/bayer_bilinear_demosaic.sv -----
// Bilinear demosaic of a GRBG Bayer pixel stream: raw 8-bit in, RGB out.
// Path: an accepted item is registered into stage 1, then its result into the
// output register on m_*. A pixel's RGB comes out with the item W+1 places
// later (W = clamped width). Throughput: one item per clock when m_* does not
// stall, set by the single line-store RAM port pair.
// Reset (aresetn low, synchronous): counters, valids cleared, width = 390;
// line stores and window are not cleared, and no clearing pass is run.
module bayer_bilinear_demosaic
    import bbd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,

    // configuration: image_width
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CFG_W-1:0] cfg_data,   // [11:0] image_width

    // raw pixel stream
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,    // [7:0] pixel_value
    input  logic             s_tuser,    // [0] kind (1 = flush tick)

    // RGB result stream
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [23:0]      m_tdata,    // [7:0] red, [15:8] green, [23:16] blue
    output logic             m_tlast,    // line_end
    output logic             m_tuser     // [0] frame_end
);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] width_reg;
    logic [CNT_W-1:0] eff_w;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg <= WIDTH_RESET;
        end else if (cfg_valid && cfg_ready) begin
            width_reg <= cfg_data;
        end
    end

    // width in use, clamped to 2..MAX_WIDTH
    always_comb begin
        if (width_reg < CFG_W'(2)) begin
            eff_w = CNT_W'(2);
        end else if (int'(width_reg) > MAX_WIDTH) begin
            eff_w = CNT_W'(MAX_WIDTH);
        end else begin
            eff_w = CNT_W'(width_reg);
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: frame counters, line-store read address
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] col_reg,   col_next;
    logic [CNT_W-1:0]  flush_reg, flush_next;
    logic [ROWS_W-1:0] rows_reg,  rows_next;
    logic              par_reg,   par_next;

    logic              in_fire;
    logic              idle_flush;
    logic              drain;
    logic [CNT_W-1:0]  k;
    logic [CNT_W-1:0]  k_inc;
    logic              k_zero;
    logic              past_end;
    s1_ctrl_t          s0_ctrl;

    logic              s1_valid_reg, s1_valid_next;
    s1_ctrl_t          s1_reg;
    logic              s1_fire;
    logic              out_free;

    assign in_fire = s_tvalid && s_tready;

    // flush tick with no frame in progress is swallowed
    assign idle_flush = s_tuser && (flush_reg == '0) && (col_reg == '0)
                     && (rows_reg == '0);
    // draining: once started, every item counts as a flush tick
    assign drain    = (flush_reg != '0) || (s_tuser && (col_reg == '0));
    assign k        = drain ? flush_reg : CNT_W'(col_reg);
    assign k_inc    = k + CNT_W'(1);
    assign k_zero   = (k == '0);
    assign past_end = (k >= eff_w);

    always_comb begin
        s0_ctrl.emit      = (!k_zero && (rows_reg >= ROWS_W'(1)))
                         || (k_zero && (rows_reg >= ROWS_W'(2)));
        s0_ctrl.drain     = drain;
        s0_ctrl.zero_read = drain && past_end;
        s0_ctrl.top_inv   = (!k_zero && (rows_reg == ROWS_W'(1)))
                         || (k_zero && (rows_reg == ROWS_W'(2)));
        s0_ctrl.bot_inv   = drain && !k_zero;
        s0_ctrl.left      = (k == CNT_W'(1));
        s0_ctrl.right     = drain ? (k_zero || past_end) : k_zero;
        // k == 0 finishes the last column of the previous row
        s0_ctrl.rpar      = k_zero ? par_reg : ~par_reg;
        s0_ctrl.cpar      = k_zero ? ~eff_w[0] : ~k[0];
        s0_ctrl.frame_end = drain && past_end;
        s0_ctrl.addr      = k[ADDR_W-1:0];
        // mid-row flush ticks act as zero pixels
        s0_ctrl.pix       = (s_tuser || drain) ? '0 : s_tdata;
    end

    always_comb begin
        col_next   = col_reg;
        flush_next = flush_reg;
        rows_next  = rows_reg;
        par_next   = par_reg;
        if (in_fire && !idle_flush) begin
            if (!drain) begin
                if (k_inc >= eff_w) begin
                    col_next = '0;
                    par_next = ~par_reg;
                    if (rows_reg != '1) begin
                        rows_next = rows_reg + ROWS_W'(1);
                    end
                end else begin
                    col_next = k_inc[ADDR_W-1:0];
                end
            end else if (past_end) begin
                col_next   = '0;
                flush_next = '0;
                rows_next  = '0;
                par_next   = 1'b0;
            end else begin
                flush_next = k_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            flush_reg <= '0;
            rows_reg  <= '0;
            par_reg   <= 1'b0;
        end else begin
            col_reg   <= col_next;
            flush_reg <= flush_next;
            rows_reg  <= rows_next;
            par_reg   <= par_next;
        end
    end

    // ------------------------------------------------------------------
    // Line stores: one RAM word holds {row two back, previous row}.
    // Read in stage 0, written back in stage 1. Back-to-back items always
    // use different columns, so a read never meets a pending write to the
    // same entry; no forwarding is needed.
    // ------------------------------------------------------------------
    logic              ram_we;
    logic              ram_re;
    logic [LS_W-1:0]   ram_wdata;
    logic [LS_W-1:0]   ram_rdata;

    assign ram_re = in_fire && !idle_flush && !s0_ctrl.zero_read;

    bbd_ram #(
        .DATA_W (LS_W),
        .DEPTH  (MAX_WIDTH)
    ) u_line_store (
        .aclk   (aclk),
        .we     (ram_we),
        .waddr  (s1_reg.addr),
        .wdata  (ram_wdata),
        .re     (ram_re),
        .raddr  (s0_ctrl.addr),
        .rdata  (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Stage 1: window shift and interpolation
    // ------------------------------------------------------------------
    assign out_free = !m_tvalid || m_tready;
    assign s1_fire  = s1_valid_reg && (!s1_reg.emit || out_free);
    assign s_tready = !s1_valid_reg || s1_fire;

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (in_fire && !idle_flush) begin
            s1_valid_next = 1'b1;
        end else if (s1_fire) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire && !idle_flush) begin
            s1_reg <= s0_ctrl;
        end
    end

    logic [PIX_W-1:0] nu, nl;
    logic [PIX_W-1:0] win_reg  [9];
    logic [PIX_W-1:0] win_next [9];
    logic [PIX_W-1:0] p        [3][3];
    logic [PIX_W:0]   horiz_sum, vert_sum;
    logic [PIX_W+1:0] cross_sum, diag_sum;
    logic [PIX_W-1:0] horiz, vert, cross_avg, diag;
    logic [PIX_W-1:0] red, green, blue;

    assign nu = s1_reg.zero_read ? '0 : ram_rdata[LS_W-1:PIX_W];
    assign nl = s1_reg.zero_read ? '0 : ram_rdata[PIX_W-1:0];

    assign ram_we    = s1_fire && !s1_reg.drain;
    assign ram_wdata = {nl, s1_reg.pix};

    // window rows: top = two rows back, middle = previous row, bottom = new
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            win_next[r*3 + 0] = win_reg[r*3 + 1];
            win_next[r*3 + 1] = win_reg[r*3 + 2];
        end
        win_next[2] = nu;
        win_next[5] = nl;
        win_next[8] = s1_reg.pix;
    end

    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            win_reg <= win_next;
        end
    end

    // edge replication: rows first, then columns
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                p[r][c] = win_next[r*3 + c];
            end
        end
        for (int c = 0; c < 3; c++) begin
            if (s1_reg.top_inv) begin
                p[0][c] = p[1][c];
            end
            if (s1_reg.bot_inv) begin
                p[2][c] = p[1][c];
            end
        end
        for (int r = 0; r < 3; r++) begin
            if (s1_reg.left) begin
                p[r][0] = p[r][1];
            end
            if (s1_reg.right) begin
                p[r][2] = p[r][1];
            end
        end
    end

    assign horiz_sum = {1'b0, p[1][0]} + {1'b0, p[1][2]};
    assign vert_sum  = {1'b0, p[0][1]} + {1'b0, p[2][1]};
    assign cross_sum = {2'b0, p[0][1]} + {2'b0, p[1][0]}
                     + {2'b0, p[1][2]} + {2'b0, p[2][1]};
    assign diag_sum  = {2'b0, p[0][0]} + {2'b0, p[0][2]}
                     + {2'b0, p[2][0]} + {2'b0, p[2][2]};
    assign horiz     = horiz_sum[PIX_W:1];
    assign vert      = vert_sum[PIX_W:1];
    assign cross_avg = cross_sum[PIX_W+1:2];
    assign diag      = diag_sum[PIX_W+1:2];

    always_comb begin
        case ({s1_reg.rpar, s1_reg.cpar})
            2'b01: begin   // red site
                red = p[1][1]; green = cross_avg; blue = diag;
            end
            2'b10: begin   // blue site
                blue = p[1][1]; green = cross_avg; red = diag;
            end
            2'b00: begin   // green on a red row
                green = p[1][1]; red = horiz; blue = vert;
            end
            default: begin // green on a blue row
                green = p[1][1]; blue = horiz; red = vert;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic        m_tvalid_reg, m_tvalid_next;
    logic [23:0] m_tdata_reg;
    logic        m_tlast_reg;
    logic        m_tuser_reg;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (s1_fire && s1_reg.emit) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && s1_reg.emit) begin
            m_tdata_reg <= {blue, green, red};
            m_tlast_reg <= s1_reg.right;
            m_tuser_reg <= s1_reg.frame_end;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // line store never sees a read and a write to one entry in a cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_we && ram_re) |-> (s1_reg.addr != s0_ctrl.addr))
        else $error("line store read/write collision");

    // the frame's last result also closes its row
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (!m_tuser || m_tlast))
        else $error("frame_end without line_end");

    // accepting the frame-ending tick returns all counters to zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && !idle_flush && s0_ctrl.frame_end) |=>
            (col_reg == '0 && flush_reg == '0 && rows_reg == '0 && !par_reg))
        else $error("counters not cleared at frame end");

    // draining only starts at a row boundary and stays there
    assert property (@(posedge aclk) disable iff (!aresetn)
        (flush_reg != '0) |-> (col_reg == '0))
        else $error("drain while a row is partly received");

endmodule
